FILE: rtl/rws_pkg.sv
// Package for the roulette wheel selector: command codes, fixed widths,
// Q16.16 constants and the sequencer state type. No dependencies.
package rws_pkg;

    localparam int CMD_W    = 1;
    localparam int IDX_W    = 8;
    localparam int SCORE_W  = 32;
    localparam int TOTAL_W  = 40;
    localparam int FRAC_W   = 16;
    localparam int COUNT_W  = 9;

    // Span = total + count * 1.0 needs one bit over the total.
    localparam int SPAN_W   = TOTAL_W + 1;
    localparam int SPAN_LO_W = 21;
    localparam int SPAN_HI_W = SPAN_W - SPAN_LO_W;
    localparam int MUL_B_W  = SPAN_LO_W;
    localparam int MUL_P_W  = FRAC_W + MUL_B_W;
    localparam int PROD_W   = FRAC_W + SPAN_W;
    // Running sum of (score + 1.0) over 256 members fits in 41 bits.
    localparam int SUM_W    = SPAN_W;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 1'b1;

    localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/rws_if.sv
// Valid/ready channel interfaces for the roulette wheel selector.
// Depends on rws_pkg for field widths.
interface rws_in_if;
    logic                          valid;
    logic                          ready;
    logic [rws_pkg::CMD_W-1:0]     cmd;
    logic [rws_pkg::IDX_W-1:0]     member_index;
    logic [rws_pkg::SCORE_W-1:0]   member_score;
    logic [rws_pkg::TOTAL_W-1:0]   weight_sum;
    logic [rws_pkg::FRAC_W-1:0]    random_fraction;

    modport source (
        output valid, cmd, member_index, member_score, weight_sum, random_fraction,
        input  ready
    );
    modport sink (
        input  valid, cmd, member_index, member_score, weight_sum, random_fraction,
        output ready
    );
endinterface

interface rws_out_if;
    logic                          valid;
    logic                          ready;
    logic [rws_pkg::IDX_W-1:0]     selected_index;

    modport source (
        output valid, selected_index,
        input  ready
    );
    modport sink (
        input  valid, selected_index,
        output ready
    );
endinterface

FILE: rtl/rws_score_mem.sv
// Score store: one write port, one registered read port.
// Depends on rws_pkg for the score width.
module rws_score_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [rws_pkg::SCORE_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [rws_pkg::SCORE_W-1:0]  rdata
);
    import rws_pkg::*;

    logic [SCORE_W-1:0] mem [DEPTH];
    logic [SCORE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rws_mul_unit.sv
// Shared 16 x 21 bit multiplier with a registered product.
// Depends on rws_pkg for operand widths.
module rws_mul_unit (
    input  logic                         clk,
    input  logic [rws_pkg::FRAC_W-1:0]   a,
    input  logic [rws_pkg::MUL_B_W-1:0]  b,
    output logic [rws_pkg::MUL_P_W-1:0]  p
);
    import rws_pkg::*;

    logic [MUL_P_W-1:0] p_reg;

    // Hold one partial product per cycle.
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

FILE: rtl/roulette_wheel_selector_top.sv
// Roulette wheel selector top level. A load transaction writes the score store directly.
// A select runs the threshold multiply (two partial products through one multiplier in
// the low, high and accumulate states), walks the members up to the pick over the one
// store read port and loads the output register; the next select is taken once the
// result has moved to the output register, so a waiting result holds it off.
// Reset clears control, count to 256.
module roulette_wheel_selector_top #(
    parameter int MAX_MEMBERS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rws_pkg::COUNT_W-1:0]   cfg_wdata,
    rws_in_if.sink                        in_ch,
    rws_out_if.source                     out_ch
);
    import rws_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_MEMBERS);
    // Members taking part never exceed the store or the 8-bit result.
    localparam int CNT_LIM = (MAX_MEMBERS < 256) ? MAX_MEMBERS : 256;

    // Configuration
    logic [COUNT_W-1:0] member_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= COUNT_W'(256);
        end
        else if (cfg_we)
        begin
            member_count_reg <= cfg_wdata;
        end
    end

    // Clamp the count to [1, CNT_LIM].
    logic [COUNT_W-1:0] cnt;
    logic [IDX_W-1:0]   cnt_m1;

    always_comb
    begin
        if (member_count_reg == '0)
        begin
            cnt = COUNT_W'(1);
        end
        else if (member_count_reg > COUNT_W'(CNT_LIM))
        begin
            cnt = COUNT_W'(CNT_LIM);
        end
        else
        begin
            cnt = member_count_reg;
        end
        cnt_m1 = IDX_W'(cnt - COUNT_W'(1));
    end

    // Sequencer registers
    state_t              state_reg, state_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [FRAC_W-1:0]   u_reg, u_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUM_W-1:0]    w_reg, w_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    result_reg, result_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;

    // Shared multiplier and score store
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [SCORE_W-1:0]  rd_data;
    logic                in_accept;
    logic                load_we;
    logic [SUM_W-1:0]    sum_step;
    logic [PROD_W-1:0]   prod_full;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    // Drop loads beyond the store.
    assign load_we     = in_accept && (in_ch.cmd == CMD_LOAD)
                         && ({24'd0, in_ch.member_index} < 32'(MAX_MEMBERS));

    // Low half of the span first, then the high half.
    assign mul_b = (state_reg == ST_MUL_HI) ? MUL_B_W'(span_reg[SPAN_W-1:SPAN_LO_W])
                                            : span_reg[SPAN_LO_W-1:0];

    rws_mul_unit u_mul (
        .clk (clk),
        .a   (u_reg),
        .b   (mul_b),
        .p   (mul_p)
    );

    rws_score_mem #(
        .DEPTH  (MAX_MEMBERS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(in_ch.member_index)),
        .wdata (in_ch.member_score),
        .raddr (ADDR_W'(issue_idx_reg)),
        .rdata (rd_data)
    );

    assign prod_full = prod_reg + (PROD_W'(mul_p) << SPAN_LO_W);
    assign sum_step  = sum_reg + SUM_W'(rd_data) + ONE_Q16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg      <= span_next;
        u_reg         <= u_next;
        prod_reg      <= prod_next;
        w_reg         <= w_next;
        sum_reg       <= sum_next;
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        result_reg    <= result_next;
        out_idx_reg   <= out_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        span_next      = span_reg;
        u_next         = u_reg;
        prod_next      = prod_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        issue_idx_next = issue_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        result_next    = result_reg;
        out_idx_next   = out_idx_reg;
        // Release the output register once the sink takes the transaction.
        out_valid_next = out_valid_reg && !out_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_ch.cmd == CMD_SELECT))
                begin
                    span_next  = SPAN_W'(in_ch.weight_sum) + (SPAN_W'(cnt) << 16);
                    u_next     = in_ch.random_fraction;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                // Low partial product is ready; high one is in flight.
                prod_next  = PROD_W'(mul_p);
                state_next = ST_MUL_ACC;
            end
            ST_MUL_ACC:
            begin
                w_next         = prod_full[PROD_W-1:16];
                sum_next       = '0;
                issue_idx_next = '0;
                chk_valid_next = 1'b0;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                // Advance the read one member ahead of the check.
                issue_idx_next = issue_idx_reg + COUNT_W'(1);
                chk_idx_next   = IDX_W'(issue_idx_reg);
                chk_valid_next = 1'b1;
                if (chk_valid_reg)
                begin
                    sum_next = sum_step;
                    // The last member doubles as the fallback pick.
                    if ((sum_step > w_reg) || (chk_idx_reg == cnt_m1))
                    begin
                        result_next    = chk_idx_reg;
                        chk_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.selected_index = out_idx_reg;

    // A result only appears out of the done state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output valid rose outside the done state");

    // The walk never checks past the last member taking part.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && chk_valid_reg) |-> (chk_idx_reg <= cnt_m1))
        else $error("walk checked a member beyond the count");

    // An accepted select always starts the multiply.
    a_select_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.cmd == CMD_SELECT) |=> (state_reg == ST_MUL_LO))
        else $error("select transaction did not start the multiply");

    // The done state only waits or returns to idle.
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (state_reg == ST_DONE || state_reg == ST_IDLE))
        else $error("bad exit from the done state");

endmodule
